// ===== hdl/avcc_to_annexb_converter_assert.svh =====
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_assert.svh
// assertion macros used by the converter checker
// ----------------------------------------------------------------------------
`ifndef AVCC_TO_ANNEXB_CONVERTER_ASSERT_SVH
`define AVCC_TO_ANNEXB_CONVERTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ACV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ACV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/acv_pkg.sv =====
// ----------------------------------------------------------------------------
// acv_pkg
// types, codes and constants of the length-prefix to start-code converter
// ----------------------------------------------------------------------------
`default_nettype none

package acv_pkg;

    localparam int CNT_W      = 20;
    localparam int ACC_W      = 32;
    localparam int START_LEN  = 4;
    localparam int IDX_W      = $clog2(START_LEN);

    localparam logic [2:0] PREFIX_RESET = 3'd4;

    localparam logic [7:0] START_CODE [START_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO_LEN = 3'd1,
        ST_PAST_END = 3'd2,
        ST_CAPACITY = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_DROP    = 4'b0100,
        PH_IDLE    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             sample_start;
        logic [CNT_W-1:0] sample_length;
        logic [CNT_W-1:0] out_capacity;
    } item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             sample_end;
        status_t          status;
        logic [CNT_W-1:0] out_length;
    } res_t;

    // work handed from the parser to the output stage
    typedef struct packed {
        logic load;
        logic start_code;
        res_t res;
    } desc_t;

    function automatic logic [2:0] eff_psize(input logic [2:0] raw);
        logic [2:0] r;
        r = raw;
        if (raw == 3'd0)
        begin
            r = 3'd1;
        end
        else if (raw inside {[3'd5:3'd7]})
        begin
            r = 3'd4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/acv_item_if.sv =====
// ----------------------------------------------------------------------------
// acv_item_if
// input channel: one sample byte per beat with sample framing
// ----------------------------------------------------------------------------
`default_nettype none

interface acv_item_if;
    import acv_pkg::*;

    logic             valid;
    logic             ready;
    logic [7:0]       data_byte;
    logic             sample_start;
    logic [CNT_W-1:0] sample_length;
    logic [CNT_W-1:0] out_capacity;

    modport source (output valid, data_byte, sample_start, sample_length, out_capacity,
                    input ready);
    modport sink   (input valid, data_byte, sample_start, sample_length, out_capacity,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/acv_res_if.sv =====
// ----------------------------------------------------------------------------
// acv_res_if
// output channel: one stream byte or sample status per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface acv_res_if;
    import acv_pkg::*;

    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             sample_end;
    logic [2:0]       status;
    logic [CNT_W-1:0] out_length;

    modport source (output valid, out_byte, byte_valid, sample_end, status, out_length,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, sample_end, status, out_length,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/acv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// acv_cfg_if
// configuration write channel for the length prefix size
// ----------------------------------------------------------------------------
`default_nettype none

interface acv_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] prefix_size;

    modport source (output valid, prefix_size, input ready);
    modport sink   (input valid, prefix_size, output ready);
endinterface

`default_nettype wire

// ===== hdl/acv_in_stage.sv =====
// ----------------------------------------------------------------------------
// acv_in_stage
// input register holding one accepted beat until the parser takes it
// ----------------------------------------------------------------------------
`default_nettype none

module acv_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    acv_item_if.sink       item,
    input  logic           take,
    output logic           s1_valid,
    output acv_pkg::item_t s1_item
);
    import acv_pkg::*;

    logic  s1_valid_reg;
    item_t s1_item_reg;

    assign item.ready = !s1_valid_reg || take;
    assign s1_valid   = s1_valid_reg;
    assign s1_item    = s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_item_reg.data_byte     <= item.data_byte;
            s1_item_reg.sample_start  <= item.sample_start;
            s1_item_reg.sample_length <= item.sample_length;
            s1_item_reg.out_capacity  <= item.out_capacity;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/acv_parser.sv =====
// ----------------------------------------------------------------------------
// acv_parser
// sample state: prefix collection, nal checks and payload counting
// ----------------------------------------------------------------------------
`default_nettype none

module acv_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  acv_pkg::item_t item,
    input  logic [2:0]     prefix_size,
    output acv_pkg::desc_t desc
);
    import acv_pkg::*;

    phase_t           phase_reg,   phase_next;
    logic [ACC_W-1:0] acc_reg,     acc_next;
    logic [2:0]       seen_reg,    seen_next;
    logic [CNT_W-1:0] rem_reg,     rem_next;
    logic [CNT_W-1:0] cons_reg,    cons_next;
    logic [CNT_W-1:0] emit_reg,    emit_next;
    logic [CNT_W-1:0] len_reg,     len_next;
    logic [CNT_W-1:0] cap_reg,     cap_next;

    // state as seen by this byte, cleared when it starts a sample
    phase_t           e_phase;
    logic [ACC_W-1:0] e_acc;
    logic [2:0]       e_seen;
    logic [CNT_W-1:0] e_rem;
    logic [CNT_W-1:0] e_cons;
    logic [CNT_W-1:0] e_emit;
    logic [CNT_W-1:0] e_len;
    logic [CNT_W-1:0] e_cap;

    logic [2:0]       psize;
    logic [CNT_W-1:0] cons_inc;
    logic [CNT_W-1:0] left_now;
    logic [CNT_W-1:0] left_in;
    logic [ACC_W-1:0] acc_new;
    logic [2:0]       seen_inc;
    logic [CNT_W:0]   room;
    logic [CNT_W-1:0] room4;
    logic             cap_bad;
    logic [CNT_W-1:0] rem_dec;
    logic             in_range;

    always_comb
    begin
        psize = eff_psize(prefix_size);

        if (item.sample_start)
        begin
            e_phase = PH_PREFIX;
            e_acc   = '0;
            e_seen  = '0;
            e_rem   = '0;
            e_cons  = '0;
            e_emit  = '0;
            e_len   = item.sample_length;
            e_cap   = item.out_capacity;
        end
        else
        begin
            e_phase = phase_reg;
            e_acc   = acc_reg;
            e_seen  = seen_reg;
            e_rem   = rem_reg;
            e_cons  = cons_reg;
            e_emit  = emit_reg;
            e_len   = len_reg;
            e_cap   = cap_reg;
        end

        in_range = e_cons < e_len;
        cons_inc = e_cons + CNT_W'(1);
        left_now = e_len - e_cons;
        left_in  = e_len - cons_inc;
        acc_new  = {e_acc[ACC_W-9:0], item.data_byte};
        seen_inc = e_seen + 3'd1;
        room     = {1'b0, e_cap} - {1'b0, e_emit};
        room4    = room[CNT_W-1:0] - CNT_W'(START_LEN);
        cap_bad  = room[CNT_W] || (room[CNT_W-1:0] < CNT_W'(START_LEN))
                   || (acc_new > {{(ACC_W-CNT_W){1'b0}}, room4});
        rem_dec  = (e_rem != '0) ? (e_rem - CNT_W'(1)) : e_rem;

        phase_next = e_phase;
        acc_next   = e_acc;
        seen_next  = e_seen;
        rem_next   = e_rem;
        cons_next  = e_cons;
        emit_next  = e_emit;
        len_next   = e_len;
        cap_next   = e_cap;

        desc                = '0;
        desc.res.status     = ST_OK;
        desc.res.out_length = e_emit;

        case (e_phase)
            PH_PREFIX:
            begin
                if (in_range)
                begin
                    cons_next = cons_inc;
                    if (e_seen == 3'd0 && left_now < {{(CNT_W-3){1'b0}}, psize})
                    begin
                        phase_next          = PH_DROP;
                        desc.load           = 1'b1;
                        desc.res.sample_end = 1'b1;
                        desc.res.status     = ST_TRUNC;
                    end
                    else
                    begin
                        acc_next  = acc_new;
                        seen_next = seen_inc;
                        if (seen_inc >= psize)
                        begin
                            seen_next = '0;
                            acc_next  = '0;
                            if (acc_new == '0)
                            begin
                                phase_next          = PH_DROP;
                                desc.load           = 1'b1;
                                desc.res.sample_end = 1'b1;
                                desc.res.status     = ST_ZERO_LEN;
                            end
                            else if (acc_new > {{(ACC_W-CNT_W){1'b0}}, left_in})
                            begin
                                phase_next          = PH_DROP;
                                desc.load           = 1'b1;
                                desc.res.sample_end = 1'b1;
                                desc.res.status     = ST_PAST_END;
                            end
                            else if (cap_bad)
                            begin
                                phase_next          = PH_DROP;
                                desc.load           = 1'b1;
                                desc.res.sample_end = 1'b1;
                                desc.res.status     = ST_CAPACITY;
                            end
                            else
                            begin
                                phase_next          = PH_PAYLOAD;
                                rem_next            = acc_new[CNT_W-1:0];
                                emit_next           = e_emit + CNT_W'(START_LEN);
                                desc.load           = 1'b1;
                                desc.start_code     = 1'b1;
                                desc.res.out_byte   = START_CODE[0];
                                desc.res.byte_valid = 1'b1;
                                desc.res.out_length = e_emit + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (in_range)
                begin
                    cons_next           = cons_inc;
                    emit_next           = e_emit + CNT_W'(1);
                    rem_next            = rem_dec;
                    desc.load           = 1'b1;
                    desc.res.out_byte   = item.data_byte;
                    desc.res.byte_valid = 1'b1;
                    desc.res.out_length = e_emit + CNT_W'(1);
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_PREFIX;
                        if (cons_inc == e_len)
                        begin
                            phase_next          = PH_IDLE;
                            desc.res.sample_end = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // dropping or finished: bytes are ignored
            end
        endcase

        if (!take)
        begin
            desc.load = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            acc_reg   <= '0;
            seen_reg  <= '0;
            rem_reg   <= '0;
            cons_reg  <= '0;
            emit_reg  <= '0;
            len_reg   <= '0;
            cap_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            rem_reg   <= rem_next;
            cons_reg  <= cons_next;
            emit_reg  <= emit_next;
            len_reg   <= len_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/acv_emitter.sv =====
// ----------------------------------------------------------------------------
// acv_emitter
// result register: one result, or the four start code beats in turn
// ----------------------------------------------------------------------------
`default_nettype none

module acv_emitter (
    input  logic           clk,
    input  logic           rst_n,
    input  acv_pkg::desc_t desc,
    output logic           em_free,
    acv_res_if.source      result
);
    import acv_pkg::*;

    logic             em_valid_reg, em_valid_next;
    logic             em_start_reg, em_start_next;
    logic [IDX_W-1:0] em_idx_reg,   em_idx_next;
    res_t             em_res_reg,   em_res_next;

    logic beat;
    logic last;

    always_comb
    begin
        beat    = em_valid_reg && result.ready;
        last    = !em_start_reg || (em_idx_reg == IDX_W'(START_LEN - 1));
        em_free = !em_valid_reg || (beat && last);

        em_valid_next = em_valid_reg;
        em_start_next = em_start_reg;
        em_idx_next   = em_idx_reg;
        em_res_next   = em_res_reg;

        if (beat && !last)
        begin
            // next start code beat
            em_idx_next            = em_idx_reg + IDX_W'(1);
            em_res_next.out_byte   = START_CODE[em_idx_next];
            em_res_next.out_length = em_res_reg.out_length + CNT_W'(1);
        end
        else if (em_free)
        begin
            em_valid_next = desc.load;
            if (desc.load)
            begin
                em_start_next = desc.start_code;
                em_idx_next   = '0;
                em_res_next   = desc.res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_start_reg <= 1'b0;
            em_idx_reg   <= '0;
        end
        else
        begin
            em_valid_reg <= em_valid_next;
            em_start_reg <= em_start_next;
            em_idx_reg   <= em_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_res_reg <= em_res_next;
    end

    assign result.valid      = em_valid_reg;
    assign result.out_byte   = em_res_reg.out_byte;
    assign result.byte_valid = em_res_reg.byte_valid;
    assign result.sample_end = em_res_reg.sample_end;
    assign result.status     = em_res_reg.status;
    assign result.out_length = em_res_reg.out_length;

endmodule

`default_nettype wire

// ===== hdl/avcc_to_annexb_converter.sv =====
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// length-prefixed h.264 sample to start-code byte stream converter
// ----------------------------------------------------------------------------
// item carries one sample byte per beat; the first beat of a sample has
// sample_start set and brings sample_length and out_capacity
// result carries the stream bytes: 00 00 00 01 before each nal, then the
// payload bytes; the last beat of a sample has sample_end, status, and
// out_length as the total written; an error ends the sample with one beat
// cfg writes the prefix size (1 to 4 bytes); always ready; the user writes it
// only when idle, which the block does not enforce; beats pass the input and
// result registers; throughput: one byte per cycle while result is ready; a
// completed prefix costs 4 result beats, so the input stalls per nal while the
// start code goes out; dropped bytes and prefix bytes not ending the prefix
// give no result; reset clears all sample state and sets the prefix size to 4
// a stalled result holds in the output register; the input register still
// takes one more beat, then ready drops until the result moves on
// ----------------------------------------------------------------------------
`default_nettype none

module avcc_to_annexb_converter (
    input  logic      clk,
    input  logic      rst_n,
    acv_cfg_if.sink   cfg,
    acv_item_if.sink  item,
    acv_res_if.source result
);
    import acv_pkg::*;

    logic [2:0] prefix_size_reg;
    logic       s1_valid;
    item_t      s1_item;
    logic       em_free;
    logic       take;
    desc_t      desc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_size_reg <= PREFIX_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            prefix_size_reg <= cfg.prefix_size;
        end
    end

    assign take = s1_valid && em_free;

    acv_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    acv_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (s1_item),
        .prefix_size (prefix_size_reg),
        .desc        (desc)
    );

    acv_emitter u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .desc    (desc),
        .em_free (em_free),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== hdl/acv_checker.sv =====
// ----------------------------------------------------------------------------
// acv_checker
// port-level checks on the result channel of the converter
// ----------------------------------------------------------------------------
`default_nettype none

`include "avcc_to_annexb_converter_assert.svh"

module acv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        sample_end,
    input logic [2:0]  status,
    input logic [19:0] out_length
);

    // an error code only ever closes a sample
    `ACV_ASSERT_IMP(a_status_at_end, out_valid && status != 3'd0, sample_end, "status without sample_end")

    // a beat without a stream byte is an error close
    `ACV_ASSERT_IMP(a_nobyte_is_error, out_valid && !byte_valid, sample_end && status != 3'd0, "empty beat not an error")

    // error codes stay within the defined set
    `ACV_ASSERT_IMP(a_status_range, out_valid, status != 3'd5 && status != 3'd6 && status != 3'd7, "undefined status")

    // a stalled beat holds
    `ACV_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_length), "result changed under stall")

endmodule

bind avcc_to_annexb_converter acv_checker u_acv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_byte   (result.out_byte),
    .byte_valid (result.byte_valid),
    .sample_end (result.sample_end),
    .status     (result.status),
    .out_length (result.out_length)
);

`default_nettype wire

// ===== tb/avcc_to_annexb_converter_test.sv =====
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_test
// self-checking bench for the length-prefix to start-code converter: sends
// byte samples, some well formed and some broken, under random pacing on
// both channels and checks every result beat against an in-bench model of
// the conversion, over the whole range of prefix sizes
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter_test;
    import acv_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RUN_LIMIT    = 200000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          ITEM_GOAL    = 260;
    localparam int          REPORT_MAX   = 10;
    localparam logic [31:0] START_WORD   = 32'h0000_0001;
    localparam logic [23:0] SIZE_PLAN    = {3'd6, 3'd3, 3'd7, 3'd2, 3'd5, 3'd0, 3'd4, 3'd1};
    localparam logic [19:0] LEN_MAX      = 20'hFFFFF;

    logic clk;
    logic rst_n;

    acv_cfg_if  cfg_bus ();
    acv_item_if in_bus ();
    acv_res_if  out_bus ();

    avcc_to_annexb_converter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus.sink),
        .item   (in_bus.sink),
        .result (out_bus.source)
    );

    // model state
    logic [2:0]  pfx_size    = 3'd4;
    phase_t      parse_state = PH_PREFIX;
    logic [31:0] len_acc     = '0;
    logic [2:0]  len_bytes   = '0;
    logic [31:0] nal_left    = '0;
    logic [19:0] consumed    = '0;
    logic [19:0] emitted     = '0;
    logic [19:0] samp_len    = '0;
    logic [19:0] samp_cap    = '0;

    res_t expected_stream[$];
    res_t seen_beat;
    res_t want_beat;
    int   fault_count  = 0;
    int   live_beats   = 0;
    bit   idling       = 1'b1;
    bit   hold_request = 1'b0;

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic int active_prefix_size();
        if (pfx_size == 3'd0)
        begin
            return 1;
        end
        if (pfx_size > 3'd4)
        begin
            return 4;
        end
        return int'(pfx_size);
    endfunction

    function automatic void expect_beat(input logic [7:0] b, input logic v, input logic e,
                                        input status_t s, input logic [19:0] l);
        res_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.sample_end = e;
        r.status     = s;
        r.out_length = l;
        expected_stream.push_back(r);
    endfunction

    function automatic void abort_sample(input status_t code);
        parse_state = PH_DROP;
        expect_beat(8'h00, 1'b0, 1'b1, code, emitted);
    endfunction

    // returns 0 when the byte is dropped without any effect
    function automatic bit convert_byte(input item_t it);
        int          psz;
        logic [31:0] nal;
        logic        last;
        psz = active_prefix_size();
        if (it.sample_start)
        begin
            samp_len    = it.sample_length;
            samp_cap    = it.out_capacity;
            consumed    = '0;
            emitted     = '0;
            len_acc     = '0;
            len_bytes   = '0;
            nal_left    = '0;
            parse_state = PH_PREFIX;
        end
        if (parse_state == PH_DROP || parse_state == PH_IDLE || consumed >= samp_len)
        begin
            return 1'b0;
        end
        if (parse_state == PH_PREFIX)
        begin
            if (len_bytes == 3'd0 && samp_len - consumed < psz)
            begin
                consumed++;
                abort_sample(ST_TRUNC);
                return 1'b1;
            end
            consumed++;
            len_acc = {len_acc[23:0], it.data_byte};
            len_bytes++;
            if (len_bytes < psz)
            begin
                return 1'b1;
            end
            len_bytes = '0;
            nal       = len_acc;
            len_acc   = '0;
            if (nal == 0)
            begin
                abort_sample(ST_ZERO_LEN);
            end
            else if (nal > samp_len - consumed)
            begin
                abort_sample(ST_PAST_END);
            end
            else if (emitted > samp_cap || samp_cap - emitted < 20'd4 ||
                     nal > samp_cap - emitted - 20'd4)
            begin
                abort_sample(ST_CAPACITY);
            end
            else
            begin
                for (int k = 3; k >= 0; k--)
                begin
                    emitted++;
                    expect_beat(START_WORD[8*k +: 8], 1'b1, 1'b0, ST_OK, emitted);
                end
                nal_left    = nal;
                parse_state = PH_PAYLOAD;
            end
            return 1'b1;
        end
        consumed++;
        emitted++;
        if (nal_left > 0)
        begin
            nal_left--;
        end
        last = 1'b0;
        if (nal_left == 0)
        begin
            parse_state = PH_PREFIX;
            if (consumed == samp_len)
            begin
                last        = 1'b1;
                parse_state = PH_IDLE;
            end
        end
        expect_beat(it.data_byte, 1'b1, last, ST_OK, emitted);
        return 1'b1;
    endfunction

    // entered and left at a falling edge
    task automatic drive_beat(input logic [7:0] b, input logic first,
                              input logic [19:0] slen, input logic [19:0] cap);
        item_t it;
        it.data_byte     = b;
        it.sample_start  = first;
        it.sample_length = slen;
        it.out_capacity  = cap;
        if (idling && $urandom_range(0, 4) == 0)
        begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.data_byte     <= b;
        in_bus.sample_start  <= first;
        in_bus.sample_length <= slen;
        in_bus.out_capacity  <= cap;
        @(posedge clk);
        while (!in_bus.ready)
        begin
            @(posedge clk);
        end
        if (convert_byte(it))
        begin
            live_beats++;
        end
        @(negedge clk);
    endtask

    task automatic quiesce();
        in_bus.valid <= 1'b0;
        while (expected_stream.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_prefix_size(input logic [2:0] v);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.prefix_size <= v;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        pfx_size = v;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_sample(input int max_len);
        logic [7:0]  body[$];
        logic [31:0] word;
        logic [19:0] slen;
        logic [19:0] cap;
        int          psz;
        int          nal_count;
        int          nal_len;
        int          need;
        int          mode;
        int          cut;
        int          extra;
        psz       = active_prefix_size();
        nal_count = $urandom_range(1, 3);
        mode      = $urandom_range(0, 99);
        need      = 0;
        extra     = 0;
        for (int n = 0; n < nal_count; n++)
        begin
            nal_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, max_len)
                                                  : $urandom_range(1, 12);
            if (mode < 6 && n == nal_count - 1)
            begin
                nal_len = 0;
            end
            need += 4 + nal_len;
            word  = nal_len;
            for (int k = psz - 1; k >= 0; k--)
            begin
                body.push_back(word[8*k +: 8]);
            end
            for (int k = 0; k < nal_len; k++)
            begin
                word = $urandom;
                body.push_back(word[7:0]);
            end
        end
        // broken prefix with random content
        if (mode >= 6 && mode < 12)
        begin
            word    = $urandom;
            body[0] = word[7:0];
        end
        slen = 20'(body.size());
        cut  = body.size();
        cap  = ($urandom_range(0, 3) == 0) ? 20'(need) : 20'($urandom_range(need, LEN_MAX));
        if (mode >= 12 && mode < 20)
        begin
            cap = (need > 4) ? 20'(need - $urandom_range(1, 4)) : 20'd0;
        end
        else if (mode >= 20 && mode < 28 && body.size() > 1)
        begin
            slen = 20'($urandom_range(1, body.size() - 1));
        end
        else if (mode >= 28 && mode < 34)
        begin
            slen = 20'($urandom_range(body.size(), LEN_MAX));
            cut  = $urandom_range(1, body.size());
        end
        else if (mode >= 34 && mode < 40)
        begin
            extra = $urandom_range(1, 3);
        end
        for (int k = 0; k < cut; k++)
        begin
            if (k == 0)
            begin
                drive_beat(body[k], 1'b1, slen, cap);
            end
            else
            begin
                drive_beat(body[k], 1'b0, 20'($urandom), 20'($urandom));
            end
        end
        for (int k = 0; k < extra; k++)
        begin
            drive_beat(8'($urandom), 1'b0, 20'($urandom), 20'($urandom));
        end
    endtask

    task automatic test_directed();
        // byte before any sample
        drive_beat(8'h5A, 1'b0, 20'd3, 20'd16);
        // one-byte nal, capacity just enough
        drive_beat(8'h00, 1'b1, 20'd5, 20'd5);
        drive_beat(8'h00, 1'b0, LEN_MAX, 20'd0);
        drive_beat(8'h00, 1'b0, 20'd0, LEN_MAX);
        drive_beat(8'h01, 1'b0, LEN_MAX, LEN_MAX);
        drive_beat(8'hFF, 1'b0, 20'd0, 20'd0);
        // after a completed sample
        drive_beat(8'hA5, 1'b0, 20'd9, 20'd9);
        // truncated prefix, then a dropped byte
        drive_beat(8'h00, 1'b1, 20'd2, LEN_MAX);
        drive_beat(8'h80, 1'b0, 20'd0, 20'd0);
        // empty sample
        drive_beat(8'h11, 1'b1, 20'd0, LEN_MAX);
        // longest sample, no capacity
        drive_beat(8'h00, 1'b1, LEN_MAX, 20'd0);
        drive_beat(8'h00, 1'b0, 20'd0, 20'd0);
        drive_beat(8'h00, 1'b0, 20'd0, 20'd0);
        drive_beat(8'h01, 1'b0, 20'd0, 20'd0);
        drive_beat(8'hFF, 1'b0, 20'd0, 20'd0);
        quiesce();
        write_prefix_size(3'd1);
        // zero length, then a nal longer than the sample
        drive_beat(8'h00, 1'b1, 20'd3, LEN_MAX);
        drive_beat(8'h05, 1'b1, 20'd3, LEN_MAX);
        // restart in the middle of a sample
        drive_beat(8'h02, 1'b1, 20'd4, LEN_MAX);
        drive_beat(8'hAA, 1'b0, 20'd0, 20'd0);
        drive_beat(8'h01, 1'b1, 20'd2, LEN_MAX);
        drive_beat(8'h55, 1'b0, 20'd0, 20'd0);
    endtask

    task automatic test_prefix_sizes();
        int goal;
        for (int i = 0; i < 8; i++)
        begin
            quiesce();
            write_prefix_size(SIZE_PLAN[3*i +: 3]);
            idling = ($urandom_range(0, 3) != 0);
            goal   = live_beats + 10;
            while (live_beats < goal)
            begin
                send_sample(40);
            end
        end
    endtask

    task automatic test_backpressure();
        quiesce();
        write_prefix_size(3'd2);
        idling       = 1'b0;
        hold_request = 1'b1;
        repeat (3) send_sample(60);
        idling = 1'b1;
    endtask

    task automatic test_full_rate();
        quiesce();
        write_prefix_size(3'd4);
        idling = 1'b0;
        do
        begin
            send_sample(40);
        end
        while (live_beats < ITEM_GOAL);
    endtask

    // result side pacing
    initial
    begin
        out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                out_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
            begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            seen_beat.out_byte   = out_bus.out_byte;
            seen_beat.byte_valid = out_bus.byte_valid;
            seen_beat.sample_end = out_bus.sample_end;
            seen_beat.status     = status_t'(out_bus.status);
            seen_beat.out_length = out_bus.out_length;
            if (expected_stream.size() == 0)
            begin
                if (fault_count < REPORT_MAX)
                begin
                    $display("unexpected beat: byte %h valid %b end %b status %0d length %0d",
                             seen_beat.out_byte, seen_beat.byte_valid, seen_beat.sample_end,
                             seen_beat.status, seen_beat.out_length);
                end
                fault_count++;
            end
            else
            begin
                want_beat = expected_stream.pop_front();
                if (seen_beat !== want_beat)
                begin
                    if (fault_count < REPORT_MAX)
                    begin
                        $display("beat mismatch: expected byte %h valid %b end %b status %0d %s",
                                 want_beat.out_byte, want_beat.byte_valid,
                                 want_beat.sample_end, want_beat.status,
                                 $sformatf("length %0d", want_beat.out_length));
                        $display("               actual   byte %h valid %b end %b status %0d %s",
                                 seen_beat.out_byte, seen_beat.byte_valid,
                                 seen_beat.sample_end, seen_beat.status,
                                 $sformatf("length %0d", seen_beat.out_length));
                    end
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT * CLK_PERIOD);
        $display("[avcc_to_annexb_converter] ERROR");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.prefix_size  = 3'd4;
        in_bus.valid         = 1'b0;
        in_bus.data_byte     = 8'h00;
        in_bus.sample_start  = 1'b0;
        in_bus.sample_length = '0;
        in_bus.out_capacity  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_prefix_sizes();
        test_backpressure();
        test_full_rate();
        quiesce();
        if (fault_count == 0 && expected_stream.size() == 0)
        begin
            $display("[avcc_to_annexb_converter] OK");
        end
        else
        begin
            $display("[avcc_to_annexb_converter] ERROR");
        end
        $finish;
    end

endmodule

// ===== avcc_to_annexb_converter.f =====
+incdir+hdl
hdl/acv_pkg.sv
hdl/acv_item_if.sv
hdl/acv_res_if.sv
hdl/acv_cfg_if.sv
hdl/acv_in_stage.sv
hdl/acv_parser.sv
hdl/acv_emitter.sv
hdl/avcc_to_annexb_converter.sv
hdl/acv_checker.sv
tb/avcc_to_annexb_converter_test.sv
